// ----- rtl/cco_pkg.sv -----
// Shared types and fixed constants for the capsule pair overlap engine.
package cco_pkg;

    localparam int FIELD_W   = 48;
    localparam int RAD_W     = 16;
    localparam int CFG_W     = 16;
    localparam int DIST_W    = 16;
    localparam int Q_BITS    = 16;
    localparam int RS_W      = RAD_W + 1;
    localparam int RND_HALF  = 128;
    localparam int RND_SHIFT = 8;

    localparam logic [CFG_W-1:0]  LIM_RESET = 16'd7;
    localparam logic [DIST_W-1:0] DIST_MAX  = 16'hFFFF;
    localparam logic [Q_BITS:0]   Q_ONE     = {1'b1, {Q_BITS{1'b0}}};

    typedef struct packed {
        logic [FIELD_W-1:0] seg_a_start;
        logic [FIELD_W-1:0] seg_a_end;
        logic [FIELD_W-1:0] seg_b_start;
        logic [FIELD_W-1:0] seg_b_end;
        logic [RAD_W-1:0]   radius_a;
        logic [RAD_W-1:0]   radius_b;
    } t_cmd;

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] distance;
    } t_result;

endpackage

// ----- rtl/cco_div.sv -----
// Pipelined restoring divider giving a clamped Q1.16 quotient, one bit per stage.
module cco_div import cco_pkg::*; #(
    parameter int W   = 77,
    parameter int SBW = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic signed [W-1:0] i_num,
    input  logic signed [W-1:0] i_den,
    input  logic [SBW-1:0]      i_side,
    output logic                o_valid,
    output logic [Q_BITS:0]     o_q,
    output logic [SBW-1:0]      o_side
);

    logic              r_v    [0:Q_BITS];
    logic              r_zero [0:Q_BITS];
    logic              r_one  [0:Q_BITS];
    logic [W-1:0]      r_rem  [0:Q_BITS];
    logic [W-1:0]      r_den  [0:Q_BITS];
    logic [Q_BITS-1:0] r_q    [0:Q_BITS];
    logic [SBW-1:0]    r_side [0:Q_BITS];

    logic n_zero;
    logic n_one;

    always_comb begin
        n_zero = i_num[W-1] || (i_num == '0);
        n_one  = !n_zero && (i_num >= i_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero[0] <= n_zero;
        r_one[0]  <= n_one;
        r_rem[0]  <= i_num;
        r_den[0]  <= i_den;
        r_q[0]    <= '0;
        r_side[0] <= i_side;
    end

    for (genvar j = 1; j <= Q_BITS; j++) begin : g_step
        logic [W-1:0] n_sh;
        logic         n_bit;

        always_comb begin
            n_sh  = r_rem[j-1] << 1;
            n_bit = (n_sh >= r_den[j-1]);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else begin
                r_v[j] <= r_v[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_zero[j] <= r_zero[j-1];
            r_one[j]  <= r_one[j-1];
            r_rem[j]  <= n_bit ? (n_sh - r_den[j-1]) : n_sh;
            r_den[j]  <= r_den[j-1];
            r_q[j]    <= {r_q[j-1][Q_BITS-2:0], n_bit};
            r_side[j] <= r_side[j-1];
        end
    end

    always_comb begin
        if (r_one[Q_BITS]) begin
            o_q = Q_ONE;
        end else if (r_zero[Q_BITS]) begin
            o_q = '0;
        end else begin
            o_q = {1'b0, r_q[Q_BITS]};
        end
    end

    assign o_valid = r_v[Q_BITS];
    assign o_side  = r_side[Q_BITS];

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[Q_BITS] && !r_zero[Q_BITS] && !r_one[Q_BITS] |->
            r_rem[Q_BITS] < r_den[Q_BITS])
        else $error("Divider remainder reached the divisor.");

    a_q_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] && r_one[0] |-> !r_zero[0] && $past(i_num) >= $past(i_den))
        else $error("Divider clamp flag set without a large numerator.");

endmodule

// ----- rtl/cco_sqrt.sv -----
// Pipelined floor integer square root, one result bit per stage.
module cco_sqrt #(
    parameter int VW  = 60,
    parameter int SBW = 1,
    localparam int RW = (VW + 1) / 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [VW-1:0]  i_val,
    input  logic [SBW-1:0] i_side,
    output logic           o_valid,
    output logic [RW-1:0]  o_root,
    output logic [SBW-1:0] o_side
);

    localparam int TW = 2 * RW + 2;

    logic           r_v    [0:RW];
    logic [TW-1:0]  r_rem  [0:RW];
    logic [RW-1:0]  r_root [0:RW];
    logic [SBW-1:0] r_side [0:RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= TW'(i_val);
        r_root[0] <= '0;
        r_side[0] <= i_side;
    end

    for (genvar j = 1; j <= RW; j++) begin : g_bit
        localparam int I = RW - j;
        logic [TW-1:0] n_trial;
        logic          n_take;

        always_comb begin
            n_trial = (TW'(r_root[j-1]) << (I + 1)) + ({{(TW-1){1'b0}}, 1'b1} << (2 * I));
            n_take  = (r_rem[j-1] >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else begin
                r_v[j] <= r_v[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[j]  <= n_take ? (r_rem[j-1] - n_trial) : r_rem[j-1];
            r_root[j] <= n_take ? (r_root[j-1] | ({{(RW-1){1'b0}}, 1'b1} << I)) : r_root[j-1];
            r_side[j] <= r_side[j-1];
        end
    end

    assign o_valid = r_v[RW];
    assign o_root  = r_root[RW];
    assign o_side  = r_side[RW];

    a_root_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[RW] |-> r_rem[RW] <= (TW'(r_root[RW]) << 1))
        else $error("Square root remainder exceeds twice the root.");

endmodule

// ----- rtl/capsule_capsule_overlap.sv -----
// Top level of the capsule pair overlap engine: closest segment distance and hit test.
//
//  channel   | handshake                     | payload
//  ----------+-------------------------------+--------------------------
//  command   | start, busy (beat: start&!busy)| i_cmd (t_cmd)
//  config    | i_cfg_valid, o_cfg_ready       | i_cfg_data (degenerate limit)
//  result    | o_valid strobe, one cycle      | o_result (t_result)
//
// One beat is accepted every cycle; busy stays low.
// The pipeline depth is set by two 17-stage dividers in series and the bit-per-stage root,
// whose result is RW = (2*COORD_BITS + 29) / 2 bits wide.
// Reset clears every valid bit and loads the degenerate limit with 7.
// The receiver takes every result, so the pipeline never stalls.
module capsule_capsule_overlap import cco_pkg::*; #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_cmd             i_cmd,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,
    output logic             o_valid,
    output t_result          o_result
);

    localparam int DW     = COORD_BITS + 1;
    localparam int PW     = 2 * DW;
    localparam int SW     = PW + 2;
    localparam int W1     = 2 * SW + 1;
    localparam int W2     = SW + 19;
    localparam int PSW    = DW + 18;
    localparam int VW     = DW + 20;
    localparam int MW     = VW - 8;
    localparam int SQW    = 2 * MW;
    localparam int SUMW   = SQW + 2;
    localparam int RW     = (SUMW + 1) / 2;
    localparam int XW     = 3 * COORD_BITS;
    localparam int EW     = (XW > FIELD_W) ? XW : FIELD_W;
    localparam int LCW    = SW + 16;
    localparam int LEN_UP = (2 * FRAC_BITS >= 16) ? 0 : (16 - 2 * FRAC_BITS);
    localparam int LIM_UP = (2 * FRAC_BITS >= 16) ? (2 * FRAC_BITS - 16) : 0;
    localparam int HW     = (SUMW > 2 * RS_W + Q_BITS) ? SUMW : (2 * RS_W + Q_BITS);
    localparam int DXW    = (RW + 1 > DIST_W + 1) ? (RW + 1) : (DIST_W + 1);

    typedef struct packed {
        logic [2:0][DW-1:0] d1;
        logic [2:0][DW-1:0] d2;
        logic [2:0][DW-1:0] rr;
        logic [RS_W-1:0]    rs;
    } t_geo;

    typedef struct packed {
        logic signed [SW-1:0] a;
        logic signed [SW-1:0] b;
        logic signed [SW-1:0] c;
        logic signed [SW-1:0] e;
        logic signed [SW-1:0] f;
    } t_dots;

    typedef struct packed {
        t_geo  g;
        t_dots d;
        logic  pa;
        logic  pe;
    } t_ctx1;

    typedef struct packed {
        t_geo            g;
        logic            q_is_t;
        logic [Q_BITS:0] other;
    } t_ctx2;

    logic [CFG_W-1:0] r_lim;

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_v9, r_v10, r_v11, r_valid;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= LIM_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_lim <= i_cfg_data;
        end
    end

    // Stage 1: unpack points, form direction and offset vectors.
    logic [EW-1:0]                w_pt [4];
    logic signed [COORD_BITS-1:0] w_c  [4][3];
    t_geo                         n_g1;
    t_geo                         r_g1;

    always_comb begin
        w_pt[0] = EW'(i_cmd.seg_a_start);
        w_pt[1] = EW'(i_cmd.seg_a_end);
        w_pt[2] = EW'(i_cmd.seg_b_start);
        w_pt[3] = EW'(i_cmd.seg_b_end);
        for (int j = 0; j < 4; j++) begin
            for (int k = 0; k < 3; k++) begin
                w_c[j][k] = signed'(w_pt[j][(2 - k) * COORD_BITS +: COORD_BITS]);
            end
        end
        for (int k = 0; k < 3; k++) begin
            n_g1.d1[k] = DW'(w_c[1][k]) - DW'(w_c[0][k]);
            n_g1.d2[k] = DW'(w_c[3][k]) - DW'(w_c[2][k]);
            n_g1.rr[k] = DW'(w_c[0][k]) - DW'(w_c[2][k]);
        end
        n_g1.rs = RS_W'(i_cmd.radius_a) + RS_W'(i_cmd.radius_b);
    end

    // Stage 2: component products.
    logic signed [PW-1:0] r_paa [3];
    logic signed [PW-1:0] r_pee [3];
    logic signed [PW-1:0] r_pff [3];
    logic signed [PW-1:0] r_pcc [3];
    logic signed [PW-1:0] r_pbb [3];
    t_geo                 r_g2;

    // Stage 3: dot products.
    t_dots n_d3;
    t_dots r_d3;
    t_geo  r_g3;

    always_comb begin
        n_d3.a = SW'(r_paa[0]) + SW'(r_paa[1]) + SW'(r_paa[2]);
        n_d3.e = SW'(r_pee[0]) + SW'(r_pee[1]) + SW'(r_pee[2]);
        n_d3.f = SW'(r_pff[0]) + SW'(r_pff[1]) + SW'(r_pff[2]);
        n_d3.c = SW'(r_pcc[0]) + SW'(r_pcc[1]) + SW'(r_pcc[2]);
        n_d3.b = SW'(r_pbb[0]) + SW'(r_pbb[1]) + SW'(r_pbb[2]);
    end

    // Stage 4: point tests and the products for the denominator and first numerator.
    logic                   n_pa4, n_pe4;
    logic                   r_pa4, r_pe4;
    logic signed [2*SW-1:0] r_ae, r_bb, r_bf, r_ce;
    t_dots                  r_d4;
    t_geo                   r_g4;

    always_comb begin
        n_pa4 = ((LCW'($unsigned(r_d3.a)) << LEN_UP) <= (LCW'(r_lim) << LIM_UP));
        n_pe4 = ((LCW'($unsigned(r_d3.e)) << LEN_UP) <= (LCW'(r_lim) << LIM_UP));
    end

    // Stage 5: denominator and first numerator.
    logic signed [W1-1:0] n_den5, n_nums5;
    logic signed [W1-1:0] r_num1, r_den1;
    t_ctx1                r_ctx5;

    always_comb begin
        n_den5  = W1'(r_ae) - W1'(r_bb);
        n_nums5 = W1'(r_bf) - W1'(r_ce);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g1 <= n_g1;
        for (int k = 0; k < 3; k++) begin
            r_paa[k] <= PW'($signed(r_g1.d1[k])) * PW'($signed(r_g1.d1[k]));
            r_pee[k] <= PW'($signed(r_g1.d2[k])) * PW'($signed(r_g1.d2[k]));
            r_pff[k] <= PW'($signed(r_g1.d2[k])) * PW'($signed(r_g1.rr[k]));
            r_pcc[k] <= PW'($signed(r_g1.d1[k])) * PW'($signed(r_g1.rr[k]));
            r_pbb[k] <= PW'($signed(r_g1.d1[k])) * PW'($signed(r_g1.d2[k]));
        end
        r_g2   <= r_g1;
        r_d3   <= n_d3;
        r_g3   <= r_g2;
        r_pa4  <= n_pa4;
        r_pe4  <= n_pe4;
        r_ae   <= (2*SW)'(r_d3.a) * (2*SW)'(r_d3.e);
        r_bb   <= (2*SW)'(r_d3.b) * (2*SW)'(r_d3.b);
        r_bf   <= (2*SW)'(r_d3.b) * (2*SW)'(r_d3.f);
        r_ce   <= (2*SW)'(r_d3.c) * (2*SW)'(r_d3.e);
        r_d4   <= r_d3;
        r_g4   <= r_g3;
        r_num1 <= (!n_den5[W1-1] && (n_den5 != '0)) ? n_nums5 : '0;
        r_den1 <= n_den5;
        r_ctx5 <= '{g: r_g4, d: r_d4, pa: r_pa4, pe: r_pe4};
    end

    logic            w_v1o;
    logic [Q_BITS:0] w_q1;
    t_ctx1           w_ctx1o;

    cco_div #(
        .W   (W1),
        .SBW ($bits(t_ctx1))
    ) u_div_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v5),
        .i_num   (r_num1),
        .i_den   (r_den1),
        .i_side  (r_ctx5),
        .o_valid (w_v1o),
        .o_q     (w_q1),
        .o_side  (w_ctx1o)
    );

    // Stage 6: numerator and denominator of t.
    logic signed [W2-1:0] r_numt, r_dent;
    logic [Q_BITS:0]      r_s1;
    t_ctx1                r_ctx6;

    // Stage 7: choose the second division.
    logic signed [W2-1:0] n_num2, n_den2, w_negc, w_bmc;
    logic                 n_qt;
    logic [Q_BITS:0]      n_other;
    logic signed [W2-1:0] r_num2, r_den2;
    t_ctx2                r_ctx7;

    always_comb begin
        w_negc = W2'(0) - W2'(r_ctx6.d.c);
        w_bmc  = W2'(r_ctx6.d.b) - W2'(r_ctx6.d.c);
        if (r_ctx6.pa) begin
            n_num2  = r_ctx6.pe ? '0 : W2'(r_ctx6.d.f);
            n_den2  = W2'(r_ctx6.d.e);
            n_qt    = 1'b1;
            n_other = '0;
        end else if (r_ctx6.pe || r_numt[W2-1]) begin
            n_num2  = w_negc;
            n_den2  = W2'(r_ctx6.d.a);
            n_qt    = 1'b0;
            n_other = '0;
        end else if (r_dent < r_numt) begin
            n_num2  = w_bmc;
            n_den2  = W2'(r_ctx6.d.a);
            n_qt    = 1'b0;
            n_other = Q_ONE;
        end else begin
            n_num2  = r_numt;
            n_den2  = r_dent;
            n_qt    = 1'b1;
            n_other = r_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            r_v6 <= w_v1o;
            r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        r_numt <= W2'(w_ctx1o.d.b) * W2'($signed({1'b0, w_q1}))
                  + (W2'(w_ctx1o.d.f) <<< Q_BITS);
        r_dent <= W2'(w_ctx1o.d.e) <<< Q_BITS;
        r_s1   <= w_q1;
        r_ctx6 <= w_ctx1o;
        r_num2 <= n_num2;
        r_den2 <= n_den2;
        r_ctx7 <= '{g: r_ctx6.g, q_is_t: n_qt, other: n_other};
    end

    logic            w_v2o;
    logic [Q_BITS:0] w_q2;
    t_ctx2           w_ctx2o;

    cco_div #(
        .W   (W2),
        .SBW ($bits(t_ctx2))
    ) u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v7),
        .i_num   (r_num2),
        .i_den   (r_den2),
        .i_side  (r_ctx7),
        .o_valid (w_v2o),
        .o_q     (w_q2),
        .o_side  (w_ctx2o)
    );

    // Stage 8: scale directions by s and t.
    logic [Q_BITS:0]       w_s, w_t;
    logic signed [PSW-1:0] r_ps [3];
    logic signed [PSW-1:0] r_pt [3];
    t_geo                  r_g8;

    assign w_s = w_ctx2o.q_is_t ? w_ctx2o.other : w_q2;
    assign w_t = w_ctx2o.q_is_t ? w_q2 : w_ctx2o.other;

    // Stage 9: closest-point difference, magnitude and rounding.
    logic signed [VW-1:0] n_v   [3];
    logic [VW-1:0]        n_mag [3];
    logic [VW:0]          n_rnd [3];
    logic [MW-1:0]        r_m   [3];
    logic [RS_W-1:0]      r_rs9;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_v[k]   = (VW'($signed(r_g8.rr[k])) <<< Q_BITS) + VW'(r_ps[k]) - VW'(r_pt[k]);
            n_mag[k] = n_v[k][VW-1] ? VW'(-n_v[k]) : VW'(n_v[k]);
            n_rnd[k] = (VW+1)'(n_mag[k]) + (VW+1)'(RND_HALF);
        end
    end

    // Stages 10 and 11: squares and their sum.
    logic [SQW-1:0]    r_sq [3];
    logic [2*RS_W-1:0] r_rs2;
    logic [SUMW-1:0]   r_sum;
    logic [2*RS_W-1:0] r_rs2b;
    logic              w_hit;

    assign w_hit = (HW'(r_sum) < (HW'(r_rs2b) << Q_BITS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v8  <= 1'b0;
            r_v9  <= 1'b0;
            r_v10 <= 1'b0;
            r_v11 <= 1'b0;
        end else begin
            r_v8  <= w_v2o;
            r_v9  <= r_v8;
            r_v10 <= r_v9;
            r_v11 <= r_v10;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_ps[k] <= PSW'($signed(w_ctx2o.g.d1[k])) * PSW'($signed({1'b0, w_s}));
            r_pt[k] <= PSW'($signed(w_ctx2o.g.d2[k])) * PSW'($signed({1'b0, w_t}));
            r_m[k]  <= MW'(n_rnd[k] >> RND_SHIFT);
            r_sq[k] <= SQW'(r_m[k]) * SQW'(r_m[k]);
        end
        r_g8   <= w_ctx2o.g;
        r_rs9  <= r_g8.rs;
        r_rs2  <= (2*RS_W)'(r_rs9) * (2*RS_W)'(r_rs9);
        r_sum  <= SUMW'(r_sq[0]) + SUMW'(r_sq[1]) + SUMW'(r_sq[2]);
        r_rs2b <= r_rs2;
    end

    logic          w_sq_valid;
    logic [RW-1:0] w_root;
    logic          w_hit_o;

    cco_sqrt #(
        .VW  (SUMW),
        .SBW (1)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v11),
        .i_val   (r_sum),
        .i_side  (w_hit),
        .o_valid (w_sq_valid),
        .o_root  (w_root),
        .o_side  (w_hit_o)
    );

    // Output: round to the output fraction and saturate.
    logic [RW:0]         n_rroot;
    logic [DXW-1:0]      n_dext;
    logic [DIST_W-1:0]   n_dist;
    t_result             r_res;

    always_comb begin
        n_rroot = (RW+1)'(w_root) + (RW+1)'(RND_HALF);
        n_dext  = DXW'(n_rroot >> RND_SHIFT);
        n_dist  = (n_dext > DXW'(DIST_MAX)) ? DIST_MAX : n_dext[DIST_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= '{hit: w_hit_o, distance: n_dist};
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> r_lim == $past(i_cfg_data))
        else $error("Degenerate limit did not take the written beat.");

    a_out_from_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_sq_valid))
        else $error("Result strobe without a finished square root.");

    a_div_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v7 |-> $past(r_v6) && $past(w_v1o, 2))
        else $error("Second division started without a first quotient.");

endmodule

// ----- tb/overlap_checker.sv -----
// Checker for the capsule overlap engine: predicts each result and compares it.
`timescale 1ns / 1ps

module overlap_checker import cco_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             busy,
    input  t_cmd             i_cmd,
    input  logic             i_cfg_valid,
    input  logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             o_valid,
    input  t_result          o_result,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_cmd_beats,
    output int               o_cfg_beats
);

    typedef logic signed [127:0] w128;

    t_result          expected_results[$];
    logic [CFG_W-1:0] point_limit;

    function automatic longint div_clamp(w128 num, w128 den);
        w128    rem;
        longint q;
        rem = num;
        q   = 0;
        if (num <= 0) return 0;
        if (num >= den) return 65536;
        for (int i = 0; i < 16; i++) begin
            rem = rem <<< 1;
            q   = q << 1;
            if (rem >= den) begin
                rem = rem - den;
                q   = q | 1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic t_result predict_overlap(t_cmd c, logic [CFG_W-1:0] lim);
        longint      p1[3], p2[3], d1[3], d2[3], r[3];
        longint      a, e, f, cc, b, s, t, v;
        logic [63:0] m, sum, root, dist_q, rs;
        w128         den, numt, dent;
        logic        pa, pe;
        t_result     res;
        a = 0; e = 0; f = 0; cc = 0; b = 0; s = 0; t = 0; sum = 0;
        for (int k = 0; k < 3; k++) begin
            p1[k] = longint'($signed(c.seg_a_start[47-16*k -: 16]));
            p2[k] = longint'($signed(c.seg_b_start[47-16*k -: 16]));
            d1[k] = longint'($signed(c.seg_a_end[47-16*k -: 16])) - p1[k];
            d2[k] = longint'($signed(c.seg_b_end[47-16*k -: 16])) - p2[k];
            r[k]  = p1[k] - p2[k];
            a  += d1[k] * d1[k];
            e  += d2[k] * d2[k];
            f  += d2[k] * r[k];
            cc += d1[k] * r[k];
            b  += d1[k] * d2[k];
        end
        pa = (a <= longint'(lim));
        pe = (e <= longint'(lim));
        if (pa && pe) begin
            s = 0;
            t = 0;
        end else if (pa) begin
            s = 0;
            t = div_clamp(w128'(f), w128'(e));
        end else if (pe) begin
            t = 0;
            s = div_clamp(w128'(-cc), w128'(a));
        end else begin
            den = w128'(a) * w128'(e) - w128'(b) * w128'(b);
            if (den > 0)
                s = div_clamp(w128'(b) * w128'(f) - w128'(cc) * w128'(e), den);
            else
                s = 0;
            numt = w128'(b) * w128'(s) + w128'(f) * 65536;
            dent = w128'(e) * 65536;
            if (numt < 0) begin
                t = 0;
                s = div_clamp(w128'(-cc), w128'(a));
            end else if (dent < numt) begin
                t = 65536;
                s = div_clamp(w128'(b - cc), w128'(a));
            end else begin
                t = div_clamp(numt, dent);
            end
        end
        for (int k = 0; k < 3; k++) begin
            v   = r[k] * 65536 + d1[k] * s - d2[k] * t;
            m   = (v < 0) ? 64'(-v) : 64'(v);
            m   = (m + 128) >> 8;
            sum = sum + m * m;
        end
        root   = floor_sqrt(sum);
        dist_q = (root + 128) >> 8;
        if (dist_q > 64'hFFFF) dist_q = 64'hFFFF;
        rs = 64'(c.radius_a) + 64'(c.radius_b);
        res.hit      = (sum < ((rs * rs) << 16));
        res.distance = dist_q[15:0];
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        t_result want;
        int      errs;
        errs = 0;
        if (!i_rst_n) begin
            point_limit  <= LIM_RESET;
            o_fail_count <= 0;
            o_cmd_beats  <= 0;
            o_cfg_beats  <= 0;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                point_limit <= i_cfg_data;
                o_cfg_beats <= o_cfg_beats + 1;
            end
            if (start && !busy) begin
                expected_results.push_back(predict_overlap(i_cmd, point_limit));
                o_cmd_beats <= o_cmd_beats + 1;
            end
            if (o_valid) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no expectation waiting");
                    errs = errs + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (o_result.hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, o_result.hit);
                        errs = errs + 1;
                    end
                    if (o_result.distance !== want.distance) begin
                        $error("distance: expected %0d, got %0d",
                               want.distance, o_result.distance);
                        errs = errs + 1;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
        end
        o_pending <= expected_results.size();
    end

endmodule

// ----- tb/tb.sv -----
// Testbench top for the capsule overlap engine: stimulus, configuration and verdict.
`timescale 1ns / 1ps

module tb;
    import cco_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    t_cmd             i_cmd;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data;
    logic             o_valid;
    t_result          o_result;
    int               fail_count, pending, cmd_beats, cfg_beats;
    int               quiet_cycles;
    bit               calm;

    capsule_capsule_overlap u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_cmd(i_cmd),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_result(o_result)
    );

    overlap_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_cmd(i_cmd),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_result(o_result), .o_fail_count(fail_count),
        .o_pending(pending), .o_cmd_beats(cmd_beats), .o_cfg_beats(cfg_beats)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic logic [47:0] pack_point(int x, int y, int z);
        return {x[15:0], y[15:0], z[15:0]};
    endfunction

    function automatic int near(int base, int spread);
        return base + $urandom_range(0, 2 * spread) - spread;
    endfunction

    function automatic t_cmd random_pair();
        t_cmd c;
        int   x, y, z, dx, dy, dz, k;
        k = $urandom_range(0, 9);
        x = near(0, 1024); y = near(0, 1024); z = near(0, 1024);
        dx = near(0, 800); dy = near(0, 800); dz = near(0, 800);
        c.seg_a_start = pack_point(x, y, z);
        c.seg_a_end   = pack_point(x + dx, y + dy, z + dz);
        c.seg_b_start = pack_point(near(x, 600), near(y, 600), near(z, 600));
        c.seg_b_end   = pack_point(near(x, 900), near(y, 900), near(z, 900));
        c.radius_a    = 16'($urandom_range(0, 600));
        c.radius_b    = 16'($urandom_range(0, 600));
        case (k)
            0, 1: begin
                c = $bits(t_cmd)'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                   $urandom, $urandom, $urandom});
            end
            2: begin
                c.seg_b_end = pack_point(near(x, 600) + 2 * dx, y + 2 * dy, z + 2 * dz);
                c.seg_b_start = pack_point(near(x, 600) + 2 * dx - dx, y + dy - dy + 5,
                                           z + dz - dz - 3);
                c.seg_b_end = pack_point(x + dx + 40, y + dy + 5, z + dz - 3);
                c.seg_b_start = pack_point(x + 40, y + 5, z - 3);
            end
            3: c.seg_a_end = pack_point(x + $urandom_range(0, 2), y, z + $urandom_range(0, 2));
            4: c.seg_b_end = c.seg_b_start ^ 48'($urandom_range(0, 3));
            default: ;
        endcase
        return c;
    endfunction

    task automatic send_cmd(t_cmd c);
        int target;
        if (!calm) begin
            while ($urandom_range(0, 99) < 14) begin
                start <= 1'b0;
                @(negedge i_clk);
            end
        end
        target = cmd_beats + 1;
        start  <= 1'b1;
        i_cmd  <= c;
        do @(negedge i_clk); while (cmd_beats != target);
    endtask

    task automatic write_limit(logic [CFG_W-1:0] value);
        int target;
        start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        target      = cfg_beats + 1;
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(negedge i_clk); while (cfg_beats != target);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_directed();
        t_cmd c;
        c = '0;
        send_cmd(c);
        c = '1;
        send_cmd(c);
        c.seg_a_start = pack_point(32767, 32767, 32767);
        c.seg_a_end   = pack_point(-32768, -32768, -32768);
        c.seg_b_start = pack_point(-32768, 32767, -32768);
        c.seg_b_end   = pack_point(32767, -32768, 32767);
        c.radius_a    = 16'hFFFF;
        c.radius_b    = 16'hFFFF;
        send_cmd(c);
        c.seg_a_start = pack_point(32767, 32767, 32767);
        c.seg_a_end   = pack_point(32767, 32767, 32767);
        c.seg_b_start = pack_point(-32768, -32768, -32768);
        c.seg_b_end   = pack_point(-32768, -32768, -32768);
        c.radius_a    = 16'd0;
        c.radius_b    = 16'd0;
        send_cmd(c);
        c.seg_a_start = pack_point(100, 0, 0);
        c.seg_a_end   = pack_point(100, 1, 1);
        c.seg_b_start = pack_point(0, 0, 0);
        c.seg_b_end   = pack_point(0, 500, 0);
        c.radius_a    = 16'd60;
        c.radius_b    = 16'd40;
        send_cmd(c);
        c.seg_a_start = pack_point(0, 0, 0);
        c.seg_a_end   = pack_point(0, 500, 0);
        c.seg_b_start = pack_point(100, 250, 0);
        c.seg_b_end   = pack_point(100, 250, 2);
        c.radius_a    = 16'd50;
        c.radius_b    = 16'd50;
        send_cmd(c);
        c.seg_b_start = pack_point(100, 100, 0);
        c.seg_b_end   = pack_point(100, 400, 0);
        send_cmd(c);
        c.seg_b_start = pack_point(0, 600, 0);
        c.seg_b_end   = pack_point(0, 900, 0);
        send_cmd(c);
        c.seg_a_start = pack_point(0, 0, 0);
        c.seg_a_end   = pack_point(256, 0, 0);
        c.seg_b_start = pack_point(-300, -200, 100);
        c.seg_b_end   = pack_point(-300, 200, 100);
        send_cmd(c);
        c.seg_b_start = pack_point(600, -200, 100);
        c.seg_b_end   = pack_point(600, 200, 100);
        send_cmd(c);
        c.seg_b_start = pack_point(-100, -200, -300);
        c.seg_b_end   = pack_point(300, 200, 300);
        send_cmd(c);
        c.seg_b_start = pack_point(128, 0, 0);
        c.seg_b_end   = pack_point(128, 0, 0);
        c.radius_a    = 16'd0;
        c.radius_b    = 16'd1;
        send_cmd(c);
    endtask

    initial begin
        logic [CFG_W-1:0] limits[5];
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cmd       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        calm        = 1'b0;
        limits      = '{16'd7, 16'd0, 16'hFFFF, 16'($urandom), 16'($urandom_range(0, 40))};
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        send_directed();
        for (int ph = 0; ph < 5; ph++) begin
            write_limit(limits[ph]);
            if (ph == 0) send_directed();
            for (int n = 0; n < 220; n++) begin
                calm = (ph == 2) && (n < 150);
                send_cmd(random_pair());
            end
        end
        calm  = 1'b0;
        start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/cco_pkg.sv
rtl/cco_div.sv
rtl/cco_sqrt.sv
rtl/capsule_capsule_overlap.sv
tb/overlap_checker.sv
tb/tb.sv
